### hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies, taken in by `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that must also hold during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/csc_pkg.sv
// shared types, constants and rom tables for the cordic sine/cosine unit
// no dependencies
package csc_pkg;

    localparam int STEP_COUNT_DEF = 32;
    localparam int TABLE_DEPTH    = 48;
    localparam int STEP_W         = 6;
    localparam int ANGLE_W        = 32;
    localparam int RESULT_W       = 32;
    localparam int VEC_W          = 34;
    localparam int RES_W          = 33;
    localparam int THR_W          = 8;
    localparam int GAIN_W         = 32;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    // register index, taken from paddr[2]
    localparam logic REG_STOP_THRESHOLD = 1'b0;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 32'sd1509949440;
    localparam logic signed [VEC_W-1:0]   ONE_Q30     = 34'sd1073741824;

    typedef logic signed [ANGLE_W-1:0]  angle_t;
    typedef logic signed [RESULT_W-1:0] result_t;
    typedef logic [STEP_W-1:0]          step_t;

    // atan(2^-i) in degrees, q8.24
    function automatic logic [GAIN_W-1:0] arctan_step(input step_t idx);
        logic [GAIN_W-1:0] v;
        unique case (idx)
            6'd0:    v = 32'd754974720;
            6'd1:    v = 32'd445687602;
            6'd2:    v = 32'd235489088;
            6'd3:    v = 32'd119537938;
            6'd4:    v = 32'd60000934;
            6'd5:    v = 32'd30029717;
            6'd6:    v = 32'd15018523;
            6'd7:    v = 32'd7509720;
            6'd8:    v = 32'd3754917;
            6'd9:    v = 32'd1877466;
            6'd10:   v = 32'd938734;
            6'd11:   v = 32'd469367;
            6'd12:   v = 32'd234684;
            6'd13:   v = 32'd117342;
            6'd14:   v = 32'd58671;
            6'd15:   v = 32'd29335;
            6'd16:   v = 32'd14668;
            6'd17:   v = 32'd7334;
            6'd18:   v = 32'd3667;
            6'd19:   v = 32'd1833;
            6'd20:   v = 32'd917;
            6'd21:   v = 32'd458;
            6'd22:   v = 32'd229;
            6'd23:   v = 32'd115;
            6'd24:   v = 32'd57;
            6'd25:   v = 32'd29;
            6'd26:   v = 32'd14;
            6'd27:   v = 32'd7;
            6'd28:   v = 32'd4;
            6'd29:   v = 32'd2;
            6'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // cumulative cosine product over the first n steps, q2.30
    function automatic logic [GAIN_W-1:0] gain_product(input step_t n);
        logic [GAIN_W-1:0] v;
        unique case (n)
            6'd0:    v = 32'd1073741824;
            6'd1:    v = 32'd759250125;
            6'd2:    v = 32'd679093957;
            6'd3:    v = 32'd658817909;
            6'd4:    v = 32'd653730436;
            6'd5:    v = 32'd652457347;
            6'd6:    v = 32'd652138997;
            6'd7:    v = 32'd652059405;
            6'd8:    v = 32'd652039507;
            6'd9:    v = 32'd652035406;
            6'd10:   v = 32'd652033289;
            6'd11:   v = 32'd652032978;
            6'd12:   v = 32'd652032900;
            6'd13:   v = 32'd652032881;
            6'd14:   v = 32'd652032876;
            default: v = 32'd652032874;
        endcase
        return v;
    endfunction

endpackage

### hdl/csc_in_if.sv
// input channel carrying one angle per transfer
// depends on csc_pkg
interface csc_in_if
    import csc_pkg::*;
();
    logic   valid;
    logic   ready;
    angle_t target_angle;

    modport source (output valid, output target_angle, input ready);
    modport sink   (input valid, input target_angle, output ready);
endinterface

### hdl/csc_out_if.sv
// output channel carrying sine, cosine and step count per transfer
// depends on csc_pkg
interface csc_out_if
    import csc_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t sine;
    result_t cosine;
    step_t   steps_taken;

    modport source (output valid, output sine, output cosine, output steps_taken, input ready);
    modport sink   (input valid, input sine, input cosine, input steps_taken, output ready);
endinterface

### hdl/cordic_sine_cosine_unit.sv
// rotation-mode cordic sine/cosine, one shared shift-add unit under a small sequencer
// steps per item: rotation in the shared unit, a stop test, multiply of y, multiply of x,
// then the output load; one item at a time, input ready again once the result
// sits in the output register
// the rotation loop does one shift-add step per cycle; reset (rst_n, async, active low)
// clears sequencer, output valid and stop_threshold
// depends on csc_pkg, csc_in_if, csc_out_if and assert_macros.svh
`include "assert_macros.svh"

module cordic_sine_cosine_unit
    import csc_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    csc_in_if.sink                in_ch,
    csc_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // steps actually available, capped at TABLE_DEPTH
    localparam int LIMIT = (STEP_COUNT > TABLE_DEPTH) ? TABLE_DEPTH : STEP_COUNT;
    localparam step_t LIMIT_IDX = STEP_W'(LIMIT);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_MULY = 3'd2;
    localparam logic [2:0] ST_MULX = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic signed [RES_W-1:0]  ANGLE_MAX = RES_W'(ANGLE_LIMIT);
    localparam logic signed [36:0]       SAT_HI    = 37'sd1073741824;
    localparam logic signed [36:0]       SAT_LO    = -37'sd1073741824;
    localparam logic signed [66:0]       ROUND_HALF = 67'sd536870912;

    // ------------------------------------------------------------------
    // configuration port: single register, decoded on paddr[2]
    // ------------------------------------------------------------------
    logic [THR_W-1:0] thr_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STOP_THRESHOLD);
    assign prdata = (paddr[2] == REG_STOP_THRESHOLD)
                  ? {{(APB_DATA_W-THR_W){1'b0}}, thr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_wr)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    logic [2:0]               state_reg, state_next;
    step_t                    idx_reg, idx_next;
    logic signed [VEC_W-1:0]  x_reg, x_next;
    logic signed [VEC_W-1:0]  y_reg, y_next;
    logic signed [RES_W-1:0]  res_reg, res_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [66:0]       prod_reg, prod_next;
    result_t                  sine_reg, sine_next;

    // output register, parts the sequencer from the sink
    logic    out_valid_reg, out_valid_next;
    result_t out_sine_reg, out_sine_next;
    result_t out_cos_reg, out_cos_next;
    step_t   out_steps_reg, out_steps_next;

    logic                     in_xfer;
    logic                     out_load;
    logic signed [RES_W-1:0]  target_ext;
    logic signed [RES_W-1:0]  target_clamp;
    logic signed [RES_W-1:0]  mag;
    logic                     stop_now;
    logic signed [VEC_W-1:0]  dx, dy;
    logic signed [RES_W-1:0]  atan_ext;
    logic signed [VEC_W-1:0]  mul_a;
    logic signed [66:0]       rounded;
    logic signed [36:0]       quot;
    result_t                  scaled;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // clamp to +/- 90 degrees
    assign target_ext = RES_W'(in_ch.target_angle);
    always_comb
    begin
        priority if (target_ext > ANGLE_MAX)
            target_clamp = ANGLE_MAX;
        else if (target_ext < -ANGLE_MAX)
            target_clamp = -ANGLE_MAX;
        else
            target_clamp = target_ext;
    end

    // stop test: residual magnitude within threshold, or table exhausted
    assign mag      = res_reg[RES_W-1] ? -res_reg : res_reg;
    assign stop_now = (idx_reg == LIMIT_IDX)
                   || (mag <= $signed({{(RES_W-THR_W){1'b0}}, thr_reg}));

    // shared shift-add unit, arithmetic shift rounds toward minus infinity
    assign dx       = y_reg >>> idx_reg;
    assign dy       = x_reg >>> idx_reg;
    assign atan_ext = $signed({1'b0, arctan_step(idx_reg)});

    // shared multiplier: y in the first scale cycle, x in the second
    assign mul_a     = (state_reg == ST_MULY) ? y_reg : x_reg;
    assign prod_next = mul_a * $signed({1'b0, gain_reg});

    // round half up, then saturate to +/- 1.0
    assign rounded = prod_reg + ROUND_HALF;
    assign quot    = rounded[66:30];
    always_comb
    begin
        priority if (quot > SAT_HI)
            scaled = RESULT_W'(SAT_HI);
        else if (quot < SAT_LO)
            scaled = RESULT_W'(SAT_LO);
        else
            scaled = RESULT_W'(quot);
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        res_next   = res_reg;
        gain_next  = gain_reg;
        sine_next  = sine_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x_next     = ONE_Q30;
                    y_next     = '0;
                    res_next   = target_clamp;
                    idx_next   = '0;
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (stop_now)
                begin
                    gain_next  = gain_product(idx_reg);
                    state_next = ST_MULY;
                end
                else
                begin
                    // zero residual rotates in the negative direction
                    if (res_reg > 0)
                    begin
                        x_next   = x_reg - dx;
                        y_next   = y_reg + dy;
                        res_next = res_reg - atan_ext;
                    end
                    else
                    begin
                        x_next   = x_reg + dx;
                        y_next   = y_reg - dy;
                        res_next = res_reg + atan_ext;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MULY:
            begin
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                sine_next  = scaled;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_sine_next  = out_sine_reg;
        out_cos_next   = out_cos_reg;
        out_steps_next = out_steps_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_sine_next  = sine_reg;
            out_cos_next   = scaled;
            out_steps_next = idx_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        res_reg       <= res_next;
        gain_reg      <= gain_next;
        prod_reg      <= prod_next;
        sine_reg      <= sine_next;
        out_sine_reg  <= out_sine_next;
        out_cos_reg   <= out_cos_next;
        out_steps_reg <= out_steps_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.sine        = out_sine_reg;
    assign out_ch.cosine      = out_cos_reg;
    assign out_ch.steps_taken = out_steps_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_RST(a_start_rot, clk, rst_n,
        in_xfer |=> (state_reg == ST_ROT) && (idx_reg == '0),
        "transfer in did not start rotation at step zero")
    `ASSERT_RST(a_no_early_stop, clk, rst_n,
        (state_reg == ST_ROT) && !stop_now
            |=> (state_reg == ST_ROT) && (idx_reg == $past(idx_reg) + 1'b1),
        "rotation stopped or skipped while residual above threshold")
    `ASSERT_RST(a_steps_bound, clk, rst_n,
        out_valid_reg |-> (out_steps_reg <= LIMIT_IDX),
        "step count beyond table limit")
    `ASSERT_RST(a_sat_range, clk, rst_n,
        out_valid_reg |-> (out_cos_reg <= RESULT_W'(SAT_HI)) && (out_cos_reg >= RESULT_W'(SAT_LO))
            && (out_sine_reg <= RESULT_W'(SAT_HI)) && (out_sine_reg >= RESULT_W'(SAT_LO)),
        "result outside saturation range")

endmodule
